// ----- hw/rtl/nematic_axis_velocity_alignment_top_defines.svh -----
// Assertion macros used by the checker.
`ifndef NEMATIC_AXIS_VELOCITY_ALIGNMENT_TOP_DEFINES_SVH
`define NEMATIC_AXIS_VELOCITY_ALIGNMENT_TOP_DEFINES_SVH
`define NAVA_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NAVA_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hw/rtl/nava_pkg.sv -----
// ----------------------------------------------------------------------------
// nava_pkg
// Types and constants of the nematic alignment averager.
// ----------------------------------------------------------------------------
package nava_pkg;
   localparam int SampleBits = 24;
   localparam int MaxPoints  = 4096;
   localparam int CountBits  = 13;
   localparam int SumBits    = 29;
   localparam int OutBits    = 16;
   localparam logic [0:0] CSR_NUM_POINTS = 1'b0;
   localparam logic [0:0] CSR_SCALE_NEG  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_D, ST_MUL_E, ST_SQ_R, ST_DIV_CA, ST_DIV_SA, ST_DIV_W,
      ST_VEC_MUL_X, ST_VEC_MUL_Y, ST_VEC_MUL_XY, ST_DIV_CV, ST_DIV_SV,
      ST_ORD_C, ST_ORD_S, ST_ORD_SQ, ST_ORD_W, ST_ACC, ST_AVG, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_SQRT, OP_DIV
   } op_type;

   typedef struct packed {
      logic          start;
      op_type        op;
      logic [63:0]   num;
      logic [63:0]   den;
      logic [5:0]    bits;
   } unit_req_type;

   typedef struct packed {
      logic          done;
      logic [63:0]   res;
   } unit_rsp_type;
endpackage

// ----- hw/rtl/nava_if.sv -----
// ----------------------------------------------------------------------------
// nava_req_if / nava_rsp_if / nava_csr_if
// Valid/ready channels of the alignment averager.
// ----------------------------------------------------------------------------
interface nava_req_if;
   logic valid;
   logic ready;
   logic signed [23:0] tensor_xx;
   logic signed [23:0] tensor_yy;
   logic signed [23:0] tensor_xy;
   logic signed [23:0] adv_vx;
   logic signed [23:0] adv_vy;
   logic signed [23:0] cm_vx;
   logic signed [23:0] cm_vy;
   modport source (output valid, tensor_xx, tensor_yy, tensor_xy, adv_vx, adv_vy,
      cm_vx, cm_vy, input ready);
   modport sink (input valid, tensor_xx, tensor_yy, tensor_xy, adv_vx, adv_vy,
      cm_vx, cm_vy, output ready);
endinterface

interface nava_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] adv_align_avg;
   logic [15:0] adv_align_weighted;
   logic [15:0] cm_align_avg;
   logic [15:0] cm_align_weighted;
   logic        degenerate_seen;
   modport source (output valid, adv_align_avg, adv_align_weighted, cm_align_avg,
      cm_align_weighted, degenerate_seen, input ready);
   modport sink (input valid, adv_align_avg, adv_align_weighted, cm_align_avg,
      cm_align_weighted, degenerate_seen, output ready);
endinterface

interface nava_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/nava_unit.sv -----
// ----------------------------------------------------------------------------
// nava_unit
// Shared iterative unit: rounded fraction or integer square root, one bit
// per cycle.
// ----------------------------------------------------------------------------
module nava_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  nava_pkg::unit_req_type req,
   output nava_pkg::unit_rsp_type rsp
);
   logic          busy_ff, busy_in;
   nava_pkg::op_type op_ff, op_in;
   logic [65:0]   rem_ff, rem_in;
   logic [63:0]   den_ff, den_in;
   logic [63:0]   q_ff, q_in;
   logic [63:0]   bit_ff, bit_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [65:0]   two_rem;
   logic [65:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      two_rem = {rem_ff[64:0], 1'b0};
      trial   = rem_ff - {2'b00, q_ff} - {2'b00, bit_ff};
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         den_in  = req.den;
         if (req.op == nava_pkg::OP_DIV) begin
            q_in   = (req.num >= req.den) ? 64'd1 : 64'd0;
            rem_in = {2'b00, (req.num >= req.den) ? req.num - req.den : req.num};
            cnt_in = req.bits;
         end else begin
            q_in   = '0;
            rem_in = {2'b00, req.num};
            bit_in = 64'h4000_0000_0000_0000;
            cnt_in = 6'd32;
         end
      end else if (busy_ff) begin
         unique case (op_ff)
            nava_pkg::OP_DIV: begin
               if (cnt_ff == 6'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  if (rem_ff >= {2'b00, den_ff} - rem_ff) q_in = q_ff + 64'd1;
               end else begin
                  cnt_in = cnt_ff - 6'd1;
                  if (two_rem >= {2'b00, den_ff}) begin
                     rem_in = two_rem - {2'b00, den_ff};
                     q_in   = {q_ff[62:0], 1'b1};
                  end else begin
                     rem_in = two_rem;
                     q_in   = {q_ff[62:0], 1'b0};
                  end
               end
            end
            default: begin
               if (cnt_ff == 6'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff - 6'd1;
                  bit_in = {2'b00, bit_ff[63:2]};
                  if (!trial[65]) begin
                     rem_in = trial;
                     q_in   = {1'b0, q_ff[63:1]} + bit_ff;
                  end else begin
                     q_in = {1'b0, q_ff[63:1]};
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.res  = q_ff;
endmodule

// ----- hw/rtl/nematic_axis_velocity_alignment_top.sv -----
// Per item, from acceptance until ready returns, the shared bit-serial unit runs up to
// ten square roots and divisions in turn.
// The last item of a frame adds four averaging divisions before the result
// transaction is offered; ready stays low until it is taken.
// Throughput: one item at a time; ready is low while an item is in work.
// Reset (synchronous, active high) clears the sums, count and flag, returns to idle and sets the point count to one.
// ----------------------------------------------------------------------------
// nematic_axis_velocity_alignment_top
// Averages deformation-axis to velocity nematic alignment over a frame.
// ----------------------------------------------------------------------------
module nematic_axis_velocity_alignment_top (
   input  logic        clock,
   input  logic        reset,
   nava_req_if.sink    req,
   nava_rsp_if.source  rsp,
   nava_csr_if.sink    csr
);
   nava_pkg::state_type state_ff, state_in;
   nava_pkg::unit_req_type ureq;
   nava_pkg::unit_rsp_type ursp;

   logic [12:0] num_points_ff, num_points_in;
   logic        scale_neg_ff, scale_neg_in;
   logic [12:0] count_ff, count_in;
   logic [28:0] sum_ff [4];
   logic [28:0] sum_in [4];
   logic        flag_ff, flag_in;
   logic [15:0] out_ff [4];
   logic [15:0] out_in [4];
   logic        out_flag_ff, out_flag_in;
   logic        vel_ff, vel_in;
   logic [1:0]  idx_ff, idx_in;
   logic        wait_ff, wait_in;

   logic signed [24:0] d_ff, d_in, e_ff, e_in, tr_ff, tr_in;
   logic signed [23:0] vx_s [4];
   logic signed [23:0] vin_ff [4];
   logic [49:0] a_ff, a_in;
   logic [49:0] b_ff, b_in;
   logic [32:0] r_ff, r_in;
   logic signed [31:0] ca_ff, ca_in, sa_ff, sa_in, cv_ff, cv_in, sv_ff, sv_in;
   logic [15:0] w_ff, w_in;
   logic signed [32:0] cs_ff, cs_in;
   logic [63:0] x_ff, x_in;
   logic [15:0] ord_ff [2];
   logic [15:0] ord_in [2];
   logic [15:0] word_ff [2];
   logic [15:0] word_in [2];
   logic [12:0] n_eff;
   logic [23:0] ux, uy;
   logic [24:0] utr, d_mag, e_mag;
   logic signed [23:0] vx_c, vy_c;
   logic [31:0] prod;
   logic [16:0] ord_sat;
   logic [32:0] wmul;
   logic [63:0] cs_sq;
   logic [28:0] sum_sel;
   logic [63:0] avg_sat;

   nava_unit u_unit (.clock(clock), .reset(reset), .req(ureq), .rsp(ursp));

   assign n_eff = (num_points_ff == 13'd0) ? 13'd1 :
                  (num_points_ff > 13'(nava_pkg::MaxPoints)) ?
                  13'(nava_pkg::MaxPoints) : num_points_ff;
   assign vx_c = vel_ff ? vin_ff[2] : vin_ff[0];
   assign vy_c = vel_ff ? vin_ff[3] : vin_ff[1];
   assign ux = vx_c[23] ? 24'(-vx_c) : 24'(vx_c);
   assign uy = vy_c[23] ? 24'(-vy_c) : 24'(vy_c);
   assign utr = tr_ff[24] ? 25'(-tr_ff) : 25'(tr_ff);
   assign d_mag = d_ff[24] ? 25'(-d_ff) : 25'(d_ff);
   assign e_mag = e_ff[24] ? 25'(-e_ff) : 25'(e_ff);
   assign cs_sq = 64'(cs_ff * cs_ff);
   assign sum_sel = sum_ff[idx_ff];
   assign vx_s[0] = req.adv_vx;
   assign vx_s[1] = req.adv_vy;
   assign vx_s[2] = req.cm_vx;
   assign vx_s[3] = req.cm_vy;

   always_comb begin
      state_in = state_ff;
      ureq = '0;
      num_points_in = num_points_ff;
      scale_neg_in = scale_neg_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      flag_in = flag_ff;
      out_in = out_ff;
      out_flag_in = out_flag_ff;
      vel_in = vel_ff;
      idx_in = idx_ff;
      wait_in = 1'b0;
      d_in = d_ff; e_in = e_ff; tr_in = tr_ff;
      a_in = a_ff; b_in = b_ff; r_in = r_ff;
      ca_in = ca_ff; sa_in = sa_ff; cv_in = cv_ff; sv_in = sv_ff;
      w_in = w_ff; cs_in = cs_ff; x_in = x_ff;
      ord_in = ord_ff; word_in = word_ff;
      prod = '0; ord_sat = '0; wmul = '0; avg_sat = '0;
      req.ready = 1'b0;
      csr.ready = (state_ff == nava_pkg::ST_IDLE);
      if (csr.valid && csr.ready) begin
         if (csr.index == 8'(nava_pkg::CSR_NUM_POINTS)) num_points_in = csr.data[12:0];
         else if (csr.index == 8'(nava_pkg::CSR_SCALE_NEG)) scale_neg_in = csr.data[0];
      end
      unique case (state_ff)
         nava_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               d_in  = 25'(req.tensor_xx) - 25'(req.tensor_yy);
               e_in  = 25'(req.tensor_xy) <<< 1;
               tr_in = 25'(req.tensor_xx) + 25'(req.tensor_yy);
               vel_in = 1'b0;
               state_in = nava_pkg::ST_MUL_D;
            end
         end
         nava_pkg::ST_MUL_D: begin
            a_in = 50'(d_ff * d_ff);
            state_in = nava_pkg::ST_MUL_E;
         end
         nava_pkg::ST_MUL_E: begin
            b_in = 50'(e_ff * e_ff);
            state_in = nava_pkg::ST_SQ_R;
            wait_in = 1'b1;
         end
         nava_pkg::ST_SQ_R: begin
            ureq.start = wait_ff;
            ureq.op = nava_pkg::OP_SQRT;
            ureq.num = 64'(a_ff) + 64'(b_ff);
            if (ursp.done) begin
               r_in = 33'(ursp.res);
               if (ursp.res == 64'd0) begin
                  ca_in = 32'sd1073741824; sa_in = '0;
                  state_in = nava_pkg::ST_DIV_W;
               end else state_in = nava_pkg::ST_DIV_CA;
               wait_in = 1'b1;
            end
         end
         nava_pkg::ST_DIV_CA, nava_pkg::ST_DIV_SA: begin
            ureq.start = wait_ff;
            ureq.op = nava_pkg::OP_DIV;
            ureq.num = (state_ff == nava_pkg::ST_DIV_CA) ? 64'(d_mag) : 64'(e_mag);
            ureq.den = 64'(r_ff);
            ureq.bits = 6'd30;
            if (ursp.done) begin
               wait_in = 1'b1;
               if (state_ff == nava_pkg::ST_DIV_CA) begin
                  ca_in = ((d_ff[24] ^ scale_neg_ff) ? -32'(ursp.res) : 32'(ursp.res));
                  state_in = nava_pkg::ST_DIV_SA;
               end else begin
                  sa_in = ((e_ff[24] ^ scale_neg_ff) ? -32'(ursp.res) : 32'(ursp.res));
                  state_in = nava_pkg::ST_DIV_W;
               end
            end
         end
         nava_pkg::ST_DIV_W: begin
            if (tr_ff == '0) begin
               w_in = '0; flag_in = 1'b1;
               state_in = nava_pkg::ST_VEC_MUL_X;
            end else if (r_ff >= 33'(utr)) begin
               w_in = 16'd32768;
               state_in = nava_pkg::ST_VEC_MUL_X;
            end else begin
               ureq.start = wait_ff;
               ureq.op = nava_pkg::OP_DIV;
               ureq.num = 64'(r_ff);
               ureq.den = 64'(utr);
               ureq.bits = 6'd15;
               if (ursp.done) begin
                  w_in = 16'(ursp.res);
                  state_in = nava_pkg::ST_VEC_MUL_X;
               end
            end
         end
         nava_pkg::ST_VEC_MUL_X: begin
            a_in = 50'(ux * ux);
            state_in = nava_pkg::ST_VEC_MUL_Y;
         end
         nava_pkg::ST_VEC_MUL_Y: begin
            b_in = 50'(uy * uy);
            state_in = nava_pkg::ST_VEC_MUL_XY;
         end
         nava_pkg::ST_VEC_MUL_XY: begin
            r_in = r_ff;
            x_in = 64'(ux * uy) << 1;
            if (a_ff == '0 && b_ff == '0) begin
               flag_in = 1'b1;
               ord_in[vel_ff] = '0;
               state_in = nava_pkg::ST_ORD_W;
            end else begin
               state_in = nava_pkg::ST_DIV_CV;
               wait_in = 1'b1;
            end
         end
         nava_pkg::ST_DIV_CV: begin
            ureq.start = wait_ff;
            ureq.op = nava_pkg::OP_DIV;
            ureq.num = (a_ff >= b_ff) ? 64'(a_ff - b_ff) : 64'(b_ff - a_ff);
            ureq.den = 64'(a_ff) + 64'(b_ff);
            ureq.bits = 6'd30;
            if (ursp.done) begin
               cv_in = (a_ff >= b_ff) ? 32'(ursp.res) : -32'(ursp.res);
               state_in = nava_pkg::ST_DIV_SV;
               wait_in = 1'b1;
            end
         end
         nava_pkg::ST_DIV_SV: begin
            ureq.start = wait_ff;
            ureq.op = nava_pkg::OP_DIV;
            ureq.num = x_ff;
            ureq.den = 64'(a_ff) + 64'(b_ff);
            ureq.bits = 6'd30;
            if (ursp.done) begin
               sv_in = (vx_c[23] != vy_c[23]) ? -32'(ursp.res) : 32'(ursp.res);
               state_in = nava_pkg::ST_ORD_C;
            end
         end
         nava_pkg::ST_ORD_C: begin
            cs_in = 33'(ca_ff) + 33'(cv_ff);
            state_in = nava_pkg::ST_ORD_S;
         end
         nava_pkg::ST_ORD_S: begin
            x_in = cs_sq;
            cs_in = 33'(sa_ff) + 33'(sv_ff);
            state_in = nava_pkg::ST_ORD_SQ;
            wait_in = 1'b1;
         end
         nava_pkg::ST_ORD_SQ: begin
            ureq.start = wait_ff;
            ureq.op = nava_pkg::OP_SQRT;
            ureq.num = x_ff + cs_sq;
            if (ursp.done) begin
               prod = 32'(ursp.res) + 32'd32768;
               ord_sat = (prod[31:16] > 16'd32768) ? 17'd32768 : 17'(prod[31:16]);
               ord_in[vel_ff] = 16'(ord_sat);
               state_in = nava_pkg::ST_ORD_W;
            end
         end
         nava_pkg::ST_ORD_W: begin
            wmul = 33'(ord_ff[vel_ff] * w_ff) + 33'd16384;
            word_in[vel_ff] = 16'(wmul[32:15]);
            if (vel_ff) state_in = nava_pkg::ST_ACC;
            else begin
               vel_in = 1'b1;
               state_in = nava_pkg::ST_VEC_MUL_X;
            end
         end
         nava_pkg::ST_ACC: begin
            sum_in[0] = sum_ff[0] + 29'(ord_ff[0]);
            sum_in[1] = sum_ff[1] + 29'(word_ff[0]);
            sum_in[2] = sum_ff[2] + 29'(ord_ff[1]);
            sum_in[3] = sum_ff[3] + 29'(word_ff[1]);
            count_in = count_ff + 13'd1;
            idx_in = '0;
            wait_in = 1'b1;
            state_in = (count_ff + 13'd1 >= n_eff) ? nava_pkg::ST_AVG : nava_pkg::ST_IDLE;
         end
         nava_pkg::ST_AVG: begin
            ureq.start = wait_ff;
            ureq.op = nava_pkg::OP_DIV;
            ureq.num = 64'(sum_sel) + 64'(n_eff >> 1);
            ureq.den = 64'(n_eff) << 29;
            ureq.bits = 6'd42;
            if (ursp.done) begin
               avg_sat = ursp.res >> 13;
               out_in[idx_ff] = (avg_sat > 64'd32768) ? 16'd32768 : 16'(avg_sat);
               wait_in = 1'b1;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  out_flag_in = flag_ff;
                  for (int i = 0; i < 4; i++) sum_in[i] = '0;
                  flag_in = 1'b0;
                  count_in = '0;
                  state_in = nava_pkg::ST_DONE;
               end
            end
         end
         nava_pkg::ST_DONE: begin
            if (rsp.ready) state_in = nava_pkg::ST_IDLE;
         end
         default: state_in = nava_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nava_pkg::ST_IDLE;
         num_points_ff <= 13'd1;
         scale_neg_ff <= 1'b0;
         count_ff <= '0;
         flag_ff <= 1'b0;
         wait_ff <= 1'b0;
         vel_ff <= 1'b0;
         idx_ff <= '0;
         for (int i = 0; i < 4; i++) sum_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         num_points_ff <= num_points_in;
         scale_neg_ff <= scale_neg_in;
         count_ff <= count_in;
         flag_ff <= flag_in;
         wait_ff <= wait_in;
         vel_ff <= vel_in;
         idx_ff <= idx_in;
         sum_ff <= sum_in;
      end
      out_ff <= out_in; out_flag_ff <= out_flag_in;
      d_ff <= d_in; e_ff <= e_in; tr_ff <= tr_in;
      a_ff <= a_in; b_ff <= b_in; r_ff <= r_in;
      ca_ff <= ca_in; sa_ff <= sa_in; cv_ff <= cv_in; sv_ff <= sv_in;
      w_ff <= w_in; cs_ff <= cs_in; x_ff <= x_in;
      ord_ff <= ord_in; word_ff <= word_in;
      if (state_ff == nava_pkg::ST_IDLE && req.valid) begin
         for (int i = 0; i < 4; i++) vin_ff[i] <= vx_s[i];
      end
   end

   assign rsp.valid = (state_ff == nava_pkg::ST_DONE);
   assign rsp.adv_align_avg = out_ff[0];
   assign rsp.adv_align_weighted = out_ff[1];
   assign rsp.cm_align_avg = out_ff[2];
   assign rsp.cm_align_weighted = out_ff[3];
   assign rsp.degenerate_seen = out_flag_ff;
endmodule

// ----- hw/rtl/nava_checker.sv -----
// ----------------------------------------------------------------------------
// nava_checker
// Port-level checks of the alignment averager.
// ----------------------------------------------------------------------------
`include "nematic_axis_velocity_alignment_top_defines.svh"
module nava_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_avg
);
   `NAVA_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")
   `NAVA_ASSERT_IMPL(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "item overlap")
   `NAVA_ASSERT_IMPL(a_no_ready_with_rsp, clock, reset, rsp_valid |-> !req_ready, "input taken during result")
   `NAVA_ASSERT_IMPL(a_avg_range, clock, reset, rsp_valid |-> rsp_avg <= 16'd32768, "average above one")
   `NAVA_ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_valid, "result after reset")
endmodule

bind nematic_axis_velocity_alignment_top nava_checker u_nava_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_avg(rsp.adv_align_avg)
);
